// ----- sv/url_query_decoder_defines.svh -----
// Assertion macros used by the checker file of the query decoder.
`ifndef URL_QUERY_DECODER_DEFINES_SVH
`define URL_QUERY_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define UQD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define UQD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/uqd_pkg.sv -----
// Package with the types, character codes and hex helpers of the query decoder.
`timescale 1ns / 1ps
package uqd_pkg;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  localparam logic [1:0] PH_NAME    = 2'd0;
  localparam logic [1:0] PH_VALUE   = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       pair_valid;
    logic       query_end;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic hex_ok(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    if (b <= 8'h39) begin
      t = b - 8'h30;
    end else if (b <= 8'h46) begin
      t = b - 8'h37;
    end else begin
      t = b - 8'h57;
    end
    return t[3:0];
  endfunction

endpackage

// ----- sv/uqd_parse.sv -----
// Per-pair parser state and the single-pass decode of one registered byte.
`timescale 1ns / 1ps
module uqd_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [7:0]    raw,
  input  logic          last,
  output uqd_pkg::push_t push
);
  import uqd_pkg::*;

  logic [1:0] phase;
  logic       at_start;
  logic [1:0] esc;
  logic [7:0] acc;
  logic       hv;

  logic [1:0] phase_next;
  logic       at_start_next;
  logic [1:0] esc_next;
  logic [7:0] acc_next;
  logic       hv_next;

  logic       e_v;
  logic [1:0] e_kind;
  logic [7:0] e_byte;
  logic       m_v;
  logic       m_pv;
  logic       m_qe;
  logic       dig_ok;
  logic [3:0] dig;
  res_t       e_res;
  res_t       m_res;

  always_comb begin
    phase_next    = phase;
    at_start_next = at_start;
    esc_next      = esc;
    acc_next      = acc;
    hv_next       = hv;
    e_v           = 1'b0;
    e_kind        = phase;
    e_byte        = acc;
    m_v           = 1'b0;
    m_pv          = 1'b0;
    m_qe          = 1'b0;
    dig_ok        = hex_ok(raw);
    dig           = hex_val(raw);

    if (raw == CH_AMP) begin
      e_v           = (esc != 2'd0) && !phase[1];
      m_v           = 1'b1;
      m_pv          = (phase == PH_VALUE);
      m_qe          = last;
      phase_next    = PH_NAME;
      at_start_next = 1'b1;
      esc_next      = 2'd0;
      acc_next      = 8'h00;
      hv_next       = 1'b1;
    end else begin
      if (phase == PH_NAME && raw == CH_EQ) begin
        e_v        = (esc != 2'd0);
        phase_next = at_start ? PH_DISCARD : PH_VALUE;
        esc_next   = 2'd0;
        acc_next   = 8'h00;
        hv_next    = 1'b1;
      end else if (phase[1]) begin
        phase_next = phase;
      end else if (esc != 2'd0) begin
        hv_next = hv & dig_ok;
        if (dig_ok && hv) begin
          acc_next = {acc[3:0], dig};
        end
        esc_next = esc - 2'd1;
        if (esc_next == 2'd0) begin
          e_v      = 1'b1;
          e_byte   = acc_next;
          acc_next = 8'h00;
          hv_next  = 1'b1;
        end
      end else if (raw == CH_PCT) begin
        esc_next = 2'd2;
        acc_next = 8'h00;
        hv_next  = 1'b1;
      end else begin
        e_v    = 1'b1;
        e_byte = (raw == CH_PLUS) ? CH_SPACE : raw;
      end
      at_start_next = 1'b0;

      if (last) begin
        if (esc_next != 2'd0 && !phase_next[1]) begin
          e_v    = 1'b1;
          e_kind = phase_next;
          e_byte = acc_next;
        end
        m_v           = 1'b1;
        m_pv          = (phase_next == PH_VALUE);
        m_qe          = 1'b1;
        phase_next    = PH_NAME;
        at_start_next = 1'b1;
        esc_next      = 2'd0;
        acc_next      = 8'h00;
        hv_next       = 1'b1;
      end
    end
  end

  always_comb begin
    e_res.kind       = e_kind;
    e_res.data       = e_byte;
    e_res.pair_valid = 1'b0;
    e_res.query_end  = 1'b0;
    e_res.run_last   = !m_v;
    m_res.kind       = KIND_MARK;
    m_res.data       = 8'h00;
    m_res.pair_valid = m_pv;
    m_res.query_end  = m_qe;
    m_res.run_last   = 1'b1;
    push.v0          = e_v | m_v;
    push.v1          = e_v & m_v;
    push.r0          = e_v ? e_res : m_res;
    push.r1          = m_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_NAME;
      at_start <= 1'b1;
      esc      <= 2'd0;
      acc      <= 8'h00;
      hv       <= 1'b1;
    end else if (go) begin
      phase    <= phase_next;
      at_start <= at_start_next;
      esc      <= esc_next;
      acc      <= acc_next;
      hv       <= hv_next;
    end
  end

endmodule

// ----- sv/uqd_resq.sv -----
// Small result queue that takes up to two results a cycle while it has room and hands out one unless stalled.
`timescale 1ns / 1ps
module uqd_resq (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  uqd_pkg::push_t push,
  output logic           room,
  output logic           res_valid,
  input  logic           res_stall,
  output uqd_pkg::res_t  head
);
  import uqd_pkg::*;

  res_t             mem [QDEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QPW:0]     count;
  logic [QPW-1:0]   wr_ptr1;
  logic [QPW:0]     n_push;
  logic             pop;

  assign wr_ptr1   = wr_ptr + {{(QPW-1){1'b0}}, 1'b1};
  assign n_push    = go ? ({{QPW{1'b0}}, push.v0} + {{QPW{1'b0}}, push.v1})
                        : {(QPW+1){1'b0}};
  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != {(QPW+1){1'b0}});
  assign room      = (count <= (QPW+1)'(QDEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (go && push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (go && push.v1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QPW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + {{(QPW-1){1'b0}}, 1'b1};
      end
      count <= count + n_push - {{QPW{1'b0}}, pop};
    end
  end

endmodule

// ----- sv/url_query_decoder.sv -----
// Top level of the form-urlencoded query decoder: input register, parser and result queue.
`timescale 1ns / 1ps
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------------------
//  byte in  | byte_valid, byte_stall | raw_byte, is_last
//  result   | res_valid, res_stall   | kind, decoded_byte, pair_valid, query_end, run_last
//
//  One raw byte is taken per cycle while byte_stall is low; a byte whose results need
//  two beats holds the result port for both, so the sustained rate is one beat per
//  cycle on the result port while res_stall is low. Results pass s1_byte, then the queue.
//  Reset clears the input register, empties the four-entry result queue and puts
//  the parser at the start of a name. A stalled result port fills the queue, and
//  the byte register then raises byte_stall until two entries are free.
module url_query_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] raw_byte,
  input  logic       is_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] kind,
  output logic [7:0] decoded_byte,
  output logic       pair_valid,
  output logic       query_end,
  output logic       run_last
);
  import uqd_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       room;
  logic       go;
  logic       accept;
  push_t      push;
  res_t       head;

  assign go         = s1_valid && room;
  assign byte_stall = s1_valid && !room;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= raw_byte;
      s1_last <= is_last;
    end
  end

  uqd_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .raw  (s1_byte),
    .last (s1_last),
    .push (push)
  );

  uqd_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  assign kind         = head.kind;
  assign decoded_byte = head.data;
  assign pair_valid   = head.pair_valid;
  assign query_end    = head.query_end;
  assign run_last     = head.run_last;

endmodule

// ----- sv/uqd_checker.sv -----
// Port-level assertion checker for the query decoder and its bind.
`timescale 1ns / 1ps
`include "url_query_decoder_defines.svh"
module uqd_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] raw_byte,
  input logic       is_last,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] kind,
  input logic [7:0] decoded_byte,
  input logic       pair_valid,
  input logic       query_end,
  input logic       run_last
);
  import uqd_pkg::*;

  // A marker that closes the string is always the final beat of its byte.
  `UQD_ASSERT_IMP(a_end_is_last, res_valid && kind == KIND_MARK && query_end, run_last, "query end marker without run_last")
  // Byte beats never carry pair flags.
  `UQD_ASSERT_IMP(a_byte_flags, res_valid && kind != KIND_MARK, !pair_valid && !query_end, "pair flags set on a byte beat")
  // A marker beat carries a zero character.
  `UQD_ASSERT_IMP(a_mark_zero, res_valid && kind == KIND_MARK, decoded_byte == 8'h00, "marker beat with a non-zero character")
  // A stalled result beat keeps its kind, character and run_last unchanged.
  `UQD_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(kind) && $stable(decoded_byte) && $stable(run_last), "stalled result beat changed")

endmodule

bind url_query_decoder uqd_checker u_uqd_checker (.*);

// ----- tb/sv/tb_url_query_decoder.sv -----
// Testbench for url_query_decoder: drives query strings, predicts every decoded beat and checks it.
`timescale 1ns / 1ps
module tb_url_query_decoder;
  import uqd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES  = 48;
  localparam int unsigned MAX_PRINTED  = 30;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] raw_byte;
  logic       is_last;
  logic       res_valid;
  logic       res_stall;
  logic [1:0] kind;
  logic [7:0] decoded_byte;
  logic       pair_valid;
  logic       query_end;
  logic       run_last;

  url_query_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .raw_byte     (raw_byte),
    .is_last      (is_last),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .decoded_byte (decoded_byte),
    .pair_valid   (pair_valid),
    .query_end    (query_end),
    .run_last     (run_last)
  );

  // Decoder state as the testbench sees it.
  logic [1:0] part_phase;
  logic       fresh_pair;
  logic [1:0] digits_due;
  logic [7:0] escape_value;
  logic       escape_clean;

  res_t        step_beats[$];
  res_t        decoded_beats_due[$];
  res_t        head_beat;
  logic [7:0]  query_bytes[$];
  logic        query_closed;

  logic        idle_on;
  logic        hold_req;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned beats_checked;
  int unsigned name_beats;
  int unsigned value_beats;
  int unsigned marker_beats;
  int unsigned valid_pairs;
  int unsigned input_held;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out with %0d beats still due.", decoded_beats_due.size());
    $display("url_query_decoder verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
  endtask

  function automatic int hex_weight(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic [1:0] part_kind();
    return (part_phase == PH_VALUE) ? KIND_VALUE : KIND_NAME;
  endfunction

  function automatic void stage_beat(input logic [1:0] k, input logic [7:0] d,
                                     input logic pv, input logic qe);
    res_t r;
    r.kind       = k;
    r.data       = d;
    r.pair_valid = pv;
    r.query_end  = qe;
    r.run_last   = 1'b0;
    if (step_beats.size() < 2) step_beats.push_back(r);
  endfunction

  function automatic void restart_pair();
    part_phase   = PH_NAME;
    fresh_pair   = 1'b1;
    digits_due   = 2'd0;
    escape_value = 8'h00;
    escape_clean = 1'b1;
  endfunction

  function automatic void flush_escape();
    if (digits_due != 2'd0 && part_phase < PH_DISCARD) begin
      stage_beat(part_kind(), escape_value, 1'b0, 1'b0);
    end
    digits_due   = 2'd0;
    escape_value = 8'h00;
    escape_clean = 1'b1;
  endfunction

  function automatic void close_pair(input logic qe);
    stage_beat(KIND_MARK, 8'h00, part_phase == PH_VALUE, qe);
    restart_pair();
  endfunction

  function automatic void decode_query_byte(input logic [7:0] b, input logic fin);
    int   w;
    res_t tail;
    step_beats = {};
    if (b == CH_AMP) begin
      flush_escape();
      close_pair(fin);
    end else begin
      if (part_phase == PH_NAME && b == CH_EQ) begin
        flush_escape();
        part_phase = fresh_pair ? PH_DISCARD : PH_VALUE;
      end else if (part_phase >= PH_DISCARD) begin
        w = 0;
      end else if (digits_due != 2'd0) begin
        w = hex_weight(b);
        if (w < 0) begin
          escape_clean = 1'b0;
        end else if (escape_clean) begin
          escape_value = {escape_value[3:0], 4'(w)};
        end
        digits_due = digits_due - 2'd1;
        if (digits_due == 2'd0) begin
          stage_beat(part_kind(), escape_value, 1'b0, 1'b0);
          escape_value = 8'h00;
          escape_clean = 1'b1;
        end
      end else if (b == CH_PCT) begin
        digits_due   = 2'd2;
        escape_value = 8'h00;
        escape_clean = 1'b1;
      end else begin
        stage_beat(part_kind(), (b == CH_PLUS) ? CH_SPACE : b, 1'b0, 1'b0);
      end
      fresh_pair = 1'b0;
      if (fin) begin
        flush_escape();
        close_pair(1'b1);
      end
    end
    if (step_beats.size() > 0) begin
      tail = step_beats.pop_back();
      tail.run_last = 1'b1;
      step_beats.push_back(tail);
    end
    foreach (step_beats[i]) decoded_beats_due.push_back(step_beats[i]);
  endfunction

  // Result side: random hold-offs while idle_on is set, plus one long hold-off on request.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && byte_valid && byte_stall) input_held++;
    if (!rst && res_valid && !res_stall) begin
      if (decoded_beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d byte %02h", kind, decoded_byte));
      end else begin
        head_beat = decoded_beats_due.pop_front();
        beats_checked++;
        if (kind !== head_beat.kind || decoded_byte !== head_beat.data ||
            pair_valid !== head_beat.pair_valid || query_end !== head_beat.query_end ||
            run_last !== head_beat.run_last) begin
          report_mismatch($sformatf(
            "beat %0d got %0d/%02h/%0b/%0b/%0b want %0d/%02h/%0b/%0b/%0b",
            beats_checked, kind, decoded_byte, pair_valid, query_end, run_last,
            head_beat.kind, head_beat.data, head_beat.pair_valid, head_beat.query_end,
            head_beat.run_last));
        end
        if (head_beat.kind == KIND_NAME) name_beats++;
        if (head_beat.kind == KIND_VALUE) value_beats++;
        if (head_beat.kind == KIND_MARK) marker_beats++;
        if (head_beat.kind == KIND_MARK && head_beat.pair_valid) valid_pairs++;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    raw_byte   <= b;
    is_last    <= fin;
    do @(posedge clk); while (byte_stall);
    decode_query_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic wait_for_drain();
    byte_valid <= 1'b0;
    while (decoded_beats_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_hex_char();
    case ($urandom_range(0, 2))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h41 + 8'($urandom_range(0, 5));
      default: return 8'h61 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] escape_digit();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return random_hex_char();
  endfunction

  function automatic void append_part(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          query_bytes.push_back(CH_PCT);
          query_bytes.push_back(escape_digit());
          query_bytes.push_back(escape_digit());
        end
        3: begin
          query_bytes.push_back(CH_PCT);
          query_bytes.push_back(random_hex_char());
        end
        4, 5: query_bytes.push_back(CH_PLUS);
        6, 7: query_bytes.push_back(8'($urandom_range(0, 255)));
        default: query_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
      endcase
    end
  endfunction

  function automatic void build_query();
    int unsigned pairs;
    query_bytes  = {};
    query_closed = 1'b1;
    pairs = $urandom_range(1, 4);
    for (int unsigned p = 0; p < pairs; p++) begin
      if (p > 0) query_bytes.push_back(CH_AMP);
      append_part($urandom_range(0, 4));
      if ($urandom_range(0, 6) != 0) begin
        query_bytes.push_back(CH_EQ);
        append_part($urandom_range(0, 5));
      end
    end
    if ($urandom_range(0, 7) == 0) query_bytes.push_back(CH_AMP);
    if (query_bytes.size() == 0) query_bytes.push_back(8'h61 + 8'($urandom_range(0, 25)));
  endfunction

  function automatic void build_noise();
    query_bytes  = {};
    query_closed = ($urandom_range(0, 1) == 0);
    repeat ($urandom_range(1, 8)) query_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_query();
    foreach (query_bytes[i]) begin
      send_byte(query_bytes[i], query_closed && i == query_bytes.size() - 1);
    end
  endtask

  task automatic test_leading_equals();
    send_byte(CH_EQ, 1'b0);
    send_byte("x", 1'b0);
    send_byte(CH_AMP, 1'b0);
  endtask

  task automatic test_escape_cut_short();
    send_byte(CH_PCT, 1'b0);
    send_byte("4", 1'b0);
    send_byte(CH_EQ, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("g", 1'b0);
    send_byte("1", 1'b0);
    send_byte(CH_AMP, 1'b0);
  endtask

  task automatic test_pair_without_equals();
    send_byte(8'h00, 1'b0);
    send_byte(CH_PLUS, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_PCT, 1'b0);
    send_byte("A", 1'b0);
    send_byte(CH_AMP, 1'b0);
  endtask

  task automatic test_end_of_string();
    send_byte(CH_AMP, 1'b1);
    send_byte("n", 1'b0);
    send_byte(CH_EQ, 1'b0);
    send_byte(CH_PCT, 1'b1);
    send_byte("a", 1'b0);
    send_byte(CH_EQ, 1'b1);
    send_byte(CH_PCT, 1'b0);
    send_byte("4", 1'b0);
    send_byte("1", 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_queries(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) build_noise();
      else build_query();
      send_query();
    end
    wait_for_drain();
  endtask

  task automatic test_backpressure();
    int unsigned target;
    idle_on  = 1'b0;
    hold_req = 1'b1;
    target = bytes_sent + 24;
    while (bytes_sent < target) begin
      build_query();
      send_query();
    end
    wait_for_drain();
  endtask

  task automatic test_no_idling(input int unsigned count);
    int unsigned target;
    idle_on = 1'b0;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      build_query();
      send_query();
    end
    wait_for_drain();
  endtask

  initial begin
    rst           = 1'b1;
    byte_valid    = 1'b0;
    raw_byte      = 8'h00;
    is_last       = 1'b0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    beats_checked = 0;
    name_beats    = 0;
    value_beats   = 0;
    marker_beats  = 0;
    valid_pairs   = 0;
    input_held    = 0;
    restart_pair();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_leading_equals();
    test_escape_cut_short();
    test_pair_without_equals();
    test_end_of_string();
    test_random_queries(340);
    test_backpressure();
    idle_on = 1'b1;
    test_random_queries(20);
    test_no_idling(60);

    $display("Sent %0d raw bytes; checked %0d name, %0d value and %0d marker beats.",
             bytes_sent, name_beats, value_beats, marker_beats);
    $display("%0d pairs were valid; the input was held off for %0d cycles; %0d mismatches.",
             valid_pairs, input_held, mismatches);
    if (mismatches == 0) begin
      $display("url_query_decoder verification clean");
    end else begin
      $display("url_query_decoder verification failed");
    end
    $finish;
  end

endmodule
